// ===== rtl/core/fixed_string_line_matcher_assert.svh =====
// Assertion macros for the fixed-string line matcher checks
`ifndef FIXED_STRING_LINE_MATCHER_ASSERT_SVH
`define FIXED_STRING_LINE_MATCHER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during rst
`define FSLM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst
`define FSLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fslm_pkg.sv =====
// Shared types and constants for the fixed-string line matcher
package fslm_pkg;

  localparam int MAX_PATTERN_DEFAULT = 16;
  localparam int LINE_BUFFER_DEFAULT = 4096;

  localparam int BYTE_W        = 8;
  localparam int LINE_NUMBER_W = 32;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int LENGTH_W      = 5;
  localparam int PATTERN_SLOTS = 16;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_FIRST  = 2'd0,
    REG_PATTERN_LAST   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

endpackage

// ===== rtl/core/fslm_text_if.sv =====
// Input channel carrying one text byte per beat
interface fslm_text_if;
  logic                          valid;
  logic                          ready;
  logic [fslm_pkg::BYTE_W-1:0]   text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// ===== rtl/core/fslm_result_if.sv =====
// Output channel carrying one annotated byte per beat
interface fslm_result_if;
  logic                               valid;
  logic                               ready;
  logic [fslm_pkg::BYTE_W-1:0]        echo_byte;
  logic [fslm_pkg::LINE_NUMBER_W-1:0] line_number;
  logic                               line_start;
  logic                               match_end;

  modport source (output valid, output echo_byte, output line_number,
                  output line_start, output match_end, input ready);
  modport sink   (input valid, input echo_byte, input line_number,
                  input line_start, input match_end, output ready);
endinterface

// ===== rtl/core/fixed_string_line_matcher.sv =====
// Fixed-string line matcher: top level
//
//   channel  dir  handshake      beat payload
//   text     in   valid/ready    text_byte
//   result   out  valid/ready    echo_byte, line_number, line_start, match_end
//   cfg      in   cfg_write      cfg_index, cfg_data
//
// One byte per cycle sustained while result is not stalled; each byte shows on
// result in the cycle after its beat is taken. All pattern compares run in
// parallel on the new byte and a shift window of the last MAX_PATTERN-1 bytes.
// rst is synchronous; the first byte after reset starts line 1.
// A stalled result holds and blocks the text channel until it is taken.
module fixed_string_line_matcher #(
  parameter int MAX_PATTERN = fslm_pkg::MAX_PATTERN_DEFAULT,
  parameter int LINE_BUFFER = fslm_pkg::LINE_BUFFER_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  fslm_text_if.sink                           text,
  fslm_result_if.source                       result,
  input  logic                                cfg_write,
  input  logic [fslm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fslm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int HIST_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int SINCE_W    = $clog2(MAX_PATTERN + 1);
  localparam int LINE_W     = $clog2(LINE_BUFFER);
  localparam int WIN_IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int BW         = fslm_pkg::BYTE_W;
  localparam int LNW        = fslm_pkg::LINE_NUMBER_W;
  localparam int LEN_W      = fslm_pkg::LENGTH_W;

  logic [fslm_pkg::CFG_DATA_W-1:0] pattern_first;
  logic [fslm_pkg::CFG_DATA_W-1:0] pattern_last;
  logic [SINCE_W-1:0]              pattern_length;
  logic [LEN_W-1:0]                length_clamped;

  logic [BW-1:0]      history [HIST_DEPTH];
  logic [LINE_W-1:0]  bytes_in_line;
  logic [SINCE_W-1:0] bytes_since_match;
  logic [LNW-1:0]     line_counter;
  logic               line_pending;

  logic               result_valid;
  logic [BW-1:0]      echo_byte;
  logic               line_start;
  logic               match_end;

  logic [BW*fslm_pkg::PATTERN_SLOTS-1:0] pattern_bytes;
  logic [BW-1:0]        win [MAX_PATTERN];
  logic [WIN_IDX_W-1:0] win_sel [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cmp_ok;

  logic               accept;
  logic [SINCE_W-1:0] since_base;
  logic [SINCE_W-1:0] since_inc;
  logic [LINE_W-1:0]  line_base;
  logic [LINE_W-1:0]  line_inc;
  logic [LNW-1:0]     line_counter_next;
  logic               hit;
  logic               line_pending_next;

  assign accept      = text.valid && text.ready;
  assign text.ready  = !result_valid || result.ready;

  assign result.valid       = result_valid;
  assign result.echo_byte   = echo_byte;
  assign result.line_number = line_counter;
  assign result.line_start  = line_start;
  assign result.match_end   = match_end;

  always_comb begin
    length_clamped = cfg_data[LEN_W-1:0];
    if (length_clamped == '0) begin
      length_clamped = LEN_W'(1);
    end else if (length_clamped > LEN_W'(MAX_PATTERN)) begin
      length_clamped = LEN_W'(MAX_PATTERN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_first  <= '0;
      pattern_last   <= '0;
      pattern_length <= SINCE_W'(1);
    end else if (cfg_write) begin
      unique case (fslm_pkg::cfg_reg_t'(cfg_index))
        fslm_pkg::REG_PATTERN_FIRST:  pattern_first  <= cfg_data;
        fslm_pkg::REG_PATTERN_LAST:   pattern_last   <= cfg_data;
        fslm_pkg::REG_PATTERN_LENGTH: pattern_length <= SINCE_W'(length_clamped);
        default: ;
      endcase
    end
  end

  assign pattern_bytes = {pattern_last, pattern_first};

  always_comb begin
    win[0] = text.text_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win[k] = history[k-1];
    end
  end

  // Pattern byte j must sit at window slot length-1-j
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      win_sel[j] = WIN_IDX_W'(pattern_length - SINCE_W'(1) - SINCE_W'(j));
      cmp_ok[j]  = (SINCE_W'(j) >= pattern_length) ||
                   (pattern_bytes[BW*j +: BW] == win[win_sel[j]]);
    end
  end

  always_comb begin
    since_base = line_pending ? '0 : bytes_since_match;
    line_base  = line_pending ? '0 : bytes_in_line;
    since_inc  = (since_base == SINCE_W'(MAX_PATTERN)) ? since_base
                                                        : since_base + SINCE_W'(1);
    line_inc   = line_base + LINE_W'(1);
    line_counter_next = line_counter;
    if (line_pending && (line_counter != '1)) begin
      line_counter_next = line_counter + LNW'(1);
    end
    hit = (since_inc >= pattern_length) && (&cmp_ok);
    line_pending_next = (text.text_byte == fslm_pkg::NEWLINE) ||
                        (line_inc >= LINE_W'(LINE_BUFFER - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid      <= 1'b0;
      bytes_in_line     <= '0;
      bytes_since_match <= '0;
      line_counter      <= '0;
      line_pending      <= 1'b1;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        history[k] <= '0;
      end
    end else begin
      if (accept) begin
        result_valid      <= 1'b1;
        bytes_in_line     <= line_inc;
        bytes_since_match <= hit ? '0 : since_inc;
        line_counter      <= line_counter_next;
        line_pending      <= line_pending_next;
        history[0]        <= text.text_byte;
        for (int k = 1; k < HIST_DEPTH; k++) begin
          history[k] <= history[k-1];
        end
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      echo_byte  <= text.text_byte;
      line_start <= line_pending;
      match_end  <= hit;
    end
  end

endmodule

// ===== rtl/core/fslm_checker.sv =====
// Port-level checks for the fixed-string line matcher, bound to the top level
`include "fixed_string_line_matcher_assert.svh"

module fslm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               text_valid,
  input logic                               text_ready,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic [fslm_pkg::BYTE_W-1:0]        res_echo_byte,
  input logic [fslm_pkg::LINE_NUMBER_W-1:0] res_line_number,
  input logic                               res_line_start,
  input logic                               res_match_end
);

  `FSLM_ASSERT_NEXT(a_beat_shows_next, text_valid && text_ready, res_valid, "text beat without result")
  `FSLM_ASSERT_SAME(a_stall_blocks_text, res_valid && !res_ready, !text_ready, "text taken while result stalled")
  `FSLM_ASSERT_SAME(a_line_from_one, res_valid, res_line_number != '0, "line number zero")
  `FSLM_ASSERT_NEXT(a_stall_holds, res_valid && !res_ready, res_valid && $stable(res_echo_byte) && $stable(res_line_number) && $stable(res_line_start) && $stable(res_match_end), "stalled result changed")

endmodule

bind fixed_string_line_matcher fslm_checker u_fslm_checker (
  .clk             (clk),
  .rst             (rst),
  .text_valid      (text.valid),
  .text_ready      (text.ready),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .res_echo_byte   (result.echo_byte),
  .res_line_number (result.line_number),
  .res_line_start  (result.line_start),
  .res_match_end   (result.match_end)
);
